FILE: sv/next_fit_slot_id_allocator_unit_macros.svh
// ----------------------------------------------------------------------------
// Next-fit slot allocator assertion macros
// Shared property shorthands, sampled on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef NEXT_FIT_SLOT_ID_ALLOCATOR_UNIT_MACROS_SVH
`define NEXT_FIT_SLOT_ID_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NFSA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nfsa: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define NFSA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nfsa: next-cycle check failed");

`endif

FILE: sv/nfsa_pkg.sv
// ----------------------------------------------------------------------------
// Next-fit slot allocator package
// Shared types and constants for the slot allocator block.
// ----------------------------------------------------------------------------
package nfsa_pkg;

  // Default pool size and fixed field widths.
  localparam int unsigned SLOTS_DEF = 256;
  localparam int unsigned SLOT_W    = 8;
  localparam int unsigned INDEX_W   = 16;
  localparam int unsigned STATUS_W  = 2;

  // Request codes.
  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  // Result status codes.
  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_CLEAR = 2'd0,
    S_IDLE  = 2'd1,
    S_SCAN  = 2'd2
  } state_e;

endpackage

FILE: sv/nfsa_map_ram.sv
// ----------------------------------------------------------------------------
// Used-map memory
// One bit per slot, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module nfsa_map_ram #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(SLOTS)-1:0] waddr_i,
  input  logic                     wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(SLOTS)-1:0] raddr_i,
  output logic                     rdata_o
);

  logic mem_q [SLOTS];
  logic rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered; the data holds between reads.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/nfsa_ctrl.sv
// ----------------------------------------------------------------------------
// Slot allocator controller
// Clears the used map after reset, handles free requests and runs the
// next-fit scan over the used map one slot per cycle.
// ----------------------------------------------------------------------------
module nfsa_ctrl #(
  parameter int unsigned SLOTS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            op_i,
  input  logic [nfsa_pkg::INDEX_W-1:0]    free_index_i,
  output logic                            result_valid_o,
  output logic [nfsa_pkg::STATUS_W-1:0]   status_o,
  output logic [nfsa_pkg::SLOT_W-1:0]     slot_o,
  output logic                            mem_we_o,
  output logic [$clog2(SLOTS)-1:0]        mem_waddr_o,
  output logic                            mem_wdata_o,
  output logic                            mem_re_o,
  output logic [$clog2(SLOTS)-1:0]        mem_raddr_o,
  input  logic                            mem_rdata_i
);
  import nfsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  // Step to the next slot, wrapping at the end of the pool.
  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] p);
    logic [IDX_W-1:0] r;
    r = (p == LAST_IDX) ? '0 : p + 1'b1;
    return r;
  endfunction

  state_e             state_q, state_d;
  logic [IDX_W-1:0]   next_ptr_q, next_ptr_d;
  logic [IDX_W-1:0]   chk_q, chk_d;
  logic [IDX_W-1:0]   iss_q, iss_d;
  logic [IDX_W-1:0]   cnt_q, cnt_d;
  logic               valid_q, valid_d;
  status_e            status_q, status_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic               in_range;
  logic               is_alloc;

  assign in_range = (32'(free_index_i) < SLOTS);
  assign is_alloc = (op_e'(op_i) == OP_ALLOC);

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (cnt_q == LAST_IDX) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start_i && is_alloc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!mem_rdata_i || (cnt_q == LAST_IDX)) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLEAR;
    endcase
  end

  // Memory controls and datapath updates.
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = cnt_q;
    mem_wdata_o = 1'b0;
    mem_re_o    = 1'b0;
    mem_raddr_o = next_ptr_q;
    next_ptr_d  = next_ptr_q;
    chk_d       = chk_q;
    iss_d       = iss_q;
    cnt_d       = cnt_q;
    valid_d     = 1'b0;
    status_d    = status_q;
    slot_d      = slot_q;
    unique case (state_q)
      S_CLEAR: begin
        // Sweep the map clear, one slot a cycle.
        mem_we_o    = 1'b1;
        mem_waddr_o = cnt_q;
        cnt_d       = (cnt_q == LAST_IDX) ? '0 : cnt_q + 1'b1;
      end
      S_IDLE: begin
        if (start_i) begin
          if (!is_alloc) begin
            // A free answers in the next cycle.
            valid_d = 1'b1;
            slot_d  = '0;
            if (in_range) begin
              mem_we_o    = 1'b1;
              mem_waddr_o = free_index_i[IDX_W-1:0];
              status_d    = ST_OK;
            end else begin
              status_d = ST_RANGE;
            end
          end else begin
            // Launch the scan at the pointer.
            mem_re_o    = 1'b1;
            mem_raddr_o = next_ptr_q;
            chk_d       = next_ptr_q;
            iss_d       = adv(next_ptr_q);
            cnt_d       = '0;
          end
        end
      end
      S_SCAN: begin
        if (!mem_rdata_i) begin
          // Free slot found: claim it and move the pointer past it.
          mem_we_o    = 1'b1;
          mem_waddr_o = chk_q;
          mem_wdata_o = 1'b1;
          next_ptr_d  = adv(chk_q);
          valid_d     = 1'b1;
          status_d    = ST_OK;
          slot_d      = SLOT_W'(chk_q);
        end else if (cnt_q == LAST_IDX) begin
          // Every slot checked and used.
          valid_d  = 1'b1;
          status_d = ST_FULL;
          slot_d   = '0;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = iss_q;
          chk_d       = iss_q;
          iss_d       = adv(iss_q);
          cnt_d       = cnt_q + 1'b1;
        end
      end
      default: begin
        cnt_d = '0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      next_ptr_q <= '0;
      cnt_q      <= '0;
      valid_q    <= 1'b0;
    end else begin
      state_q    <= state_d;
      next_ptr_q <= next_ptr_d;
      cnt_q      <= cnt_d;
      valid_q    <= valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    chk_q    <= chk_d;
    iss_q    <= iss_d;
    status_q <= status_d;
    slot_q   <= slot_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign status_o       = status_q;
  assign slot_o         = slot_q;

endmodule

FILE: sv/next_fit_slot_id_allocator_unit.sv
// ----------------------------------------------------------------------------
// Next-fit slot identifier allocator
// Hands out slot numbers from a used map with a rotating next-fit pointer.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Beat contents
//  request   start, busy               op_i, free_index_i
//  result    result_valid_o (strobe)   status_o, slot_o
//
//  A free beat answers in the cycle after it is taken; busy stays low.
//  An allocate beat runs a scan that reads the used-map memory one slot
//  per cycle from the pointer, so a full pool costs SLOTS reads.
//  After reset the map is cleared with busy high.
//  The result strobe lasts one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module next_fit_slot_id_allocator_unit #(
  parameter int unsigned SLOTS = nfsa_pkg::SLOTS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic                            op_i,
  input  logic [nfsa_pkg::INDEX_W-1:0]    free_index_i,
  output logic                            result_valid_o,
  output logic [nfsa_pkg::STATUS_W-1:0]   status_o,
  output logic [nfsa_pkg::SLOT_W-1:0]     slot_o
);
  import nfsa_pkg::*;

  localparam int unsigned IDX_W = $clog2(SLOTS);

  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic             mem_wdata;
  logic             mem_re;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_rdata;

  // Sequencer for clear, free and scan.
  nfsa_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_o         (busy),
    .op_i           (op_i),
    .free_index_i   (free_index_i),
    .result_valid_o (result_valid_o),
    .status_o       (status_o),
    .slot_o         (slot_o),
    .mem_we_o       (mem_we),
    .mem_waddr_o    (mem_waddr),
    .mem_wdata_o    (mem_wdata),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .mem_rdata_i    (mem_rdata)
  );

  // Used-map storage.
  nfsa_map_ram #(
    .SLOTS (SLOTS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

FILE: sv/nfsa_checker.sv
// ----------------------------------------------------------------------------
// Slot allocator port checker
// Watches the top-level ports for result timing and status consistency.
// ----------------------------------------------------------------------------
`include "next_fit_slot_id_allocator_unit_macros.svh"

module nfsa_checker #(
  parameter int unsigned SLOTS = nfsa_pkg::SLOTS_DEF
) (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start,
  input logic                            busy,
  input logic                            op_i,
  input logic [nfsa_pkg::INDEX_W-1:0]    free_index_i,
  input logic                            result_valid_o,
  input logic [nfsa_pkg::STATUS_W-1:0]   status_o,
  input logic [nfsa_pkg::SLOT_W-1:0]     slot_o
);
  import nfsa_pkg::*;

  logic take_free;
  logic take_alloc;

  assign take_free  = start && !busy && (op_i == OP_FREE);
  assign take_alloc = start && !busy && (op_i == OP_ALLOC);

  // A free beat is answered in the very next cycle.
  `NFSA_ASSERT_NEXT(a_free_answers, take_free, result_valid_o && !busy)
  // An allocate beat always enters the scan.
  `NFSA_ASSERT_NEXT(a_alloc_scans, take_alloc, busy && !result_valid_o)
  // Failed requests never carry a slot number.
  `NFSA_ASSERT_SAME(a_fail_slot_zero, result_valid_o && (status_o != ST_OK), slot_o == '0)
  // A range error only follows a free beat with an index past the pool.
  `NFSA_ASSERT_SAME(a_range_cause, result_valid_o && (status_o == ST_RANGE),
    $past(take_free) && ($past(32'(free_index_i)) >= SLOTS))

endmodule

bind next_fit_slot_id_allocator_unit nfsa_checker #(
  .SLOTS (SLOTS)
) u_nfsa_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .op_i           (op_i),
  .free_index_i   (free_index_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .slot_o         (slot_o)
);

FILE: dv/next_fit_slot_id_allocator_unit_tb.sv
// ----------------------------------------------------------------------------
// Next-fit slot allocator testbench
// Drives allocate and free beats through the start/busy handshake and checks
// every result strobe against a shadow used map with its own next-fit pointer.
// A short directed run covers the field extremes and corner cases. Random
// segments then fill the pool until it reports full, drain it and churn it.
// ----------------------------------------------------------------------------
module next_fit_slot_id_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nfsa_pkg::*;

  localparam int NSLOTS      = SLOTS_DEF;
  localparam int RANDOM_REQS = 650;
  localparam int CYCLE_LIMIT = 1000000;

  // One request beat together with the answer it must produce.
  typedef struct {
    op_e                op;
    logic [INDEX_W-1:0] index;
    bit                 hold;
    status_e            want_status;
    logic [SLOT_W-1:0]  want_slot;
  } request_t;

  typedef struct {
    status_e           status;
    logic [SLOT_W-1:0] slot;
  } answer_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic                op_i = OP_ALLOC;
  logic [INDEX_W-1:0]  free_index_i = '0;
  logic                result_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [SLOT_W-1:0]   slot_o;

  request_t request_q[$];
  answer_t  answer_q[$];
  request_t staged;

  // Shadow copy of the allocator state.
  bit [NSLOTS-1:0] shadow_used;
  int              shadow_ptr;

  int issued_cnt;
  int done_cnt;
  int error_cnt;
  int cycle_cnt;
  int grant_cnt;
  int full_cnt;
  int range_cnt;
  int release_cnt;

  next_fit_slot_id_allocator_unit #(
    .SLOTS(NSLOTS)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .op_i(op_i),
    .free_index_i(free_index_i),
    .result_valid_o(result_valid_o),
    .status_o(status_o),
    .slot_o(slot_o)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Queue one request and work out its answer on the shadow state.
  task automatic add_request(input op_e op, input logic [INDEX_W-1:0] idx, input bit hold);
    request_t r;
    int       p;
    bit       found;
    r.op = op;
    r.index = idx;
    r.hold = hold;
    r.want_status = ST_OK;
    r.want_slot = '0;
    if (op == OP_FREE) begin
      if (idx >= NSLOTS) begin
        r.want_status = ST_RANGE;
        range_cnt++;
      end else begin
        shadow_used[idx] = 1'b0;
        release_cnt++;
      end
    end else begin
      found = 1'b0;
      p = shadow_ptr;
      for (int n = 0; n < NSLOTS && !found; n++) begin
        if (!shadow_used[p]) begin
          found = 1'b1;
          shadow_used[p] = 1'b1;
          shadow_ptr = (p == NSLOTS - 1) ? 0 : p + 1;
          r.want_slot = p[SLOT_W-1:0];
        end else begin
          p = (p == NSLOTS - 1) ? 0 : p + 1;
        end
      end
      if (found) begin
        grant_cnt++;
      end else begin
        r.want_status = ST_FULL;
        full_cnt++;
      end
    end
    request_q.push_back(r);
  endtask

  // Free beat: mostly a slot in use, sometimes any slot, sometimes out of range.
  task automatic add_random_free(input int pct_used, input bit hold);
    int roll;
    int first;
    int pick;
    roll = $urandom_range(0, 99);
    pick = -1;
    if (roll < pct_used) begin
      first = $urandom_range(0, NSLOTS - 1);
      for (int k = 0; k < NSLOTS && pick < 0; k++) begin
        if (shadow_used[(first + k) % NSLOTS]) pick = (first + k) % NSLOTS;
      end
    end
    if (pick < 0 && roll < 90) pick = $urandom_range(0, NSLOTS - 1);
    if (pick < 0) pick = $urandom_range(NSLOTS, 65535);
    add_request(OP_FREE, pick[INDEX_W-1:0], hold);
  endtask

  task automatic add_random_request(input int pct_alloc, input bit hold);
    if ($urandom_range(0, 99) < pct_alloc) begin
      add_request(OP_ALLOC, INDEX_W'($urandom_range(0, 65535)), hold);
    end else begin
      add_random_free(75, hold);
    end
  endtask

  // Driver: present the next beat once the current one is taken.
  always @(posedge clk_i or negedge rst_ni) begin
    bit beat_taken;
    bit quiet;
    bit idle_now;
    if (!rst_ni) begin
      start <= 1'b0;
      op_i <= OP_ALLOC;
      free_index_i <= '0;
    end else begin
      beat_taken = start && !busy;
      if (beat_taken) begin
        answer_q.push_back('{status: staged.want_status, slot: staged.want_slot});
        issued_cnt++;
      end
      // A long stretch in the middle of the run goes without gaps.
      quiet = issued_cnt >= 250 && issued_cnt < 420;
      idle_now = !quiet && $urandom_range(0, 99) < 10;
      if (!start || beat_taken) begin
        if (request_q.size() != 0 && !idle_now &&
            (!request_q[0].hold || issued_cnt == done_cnt + int'(result_valid_o))) begin
          staged = request_q.pop_front();
          start <= 1'b1;
          op_i <= staged.op;
          free_index_i <= staged.index;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is matched against the oldest outstanding answer.
  always @(posedge clk_i) begin
    answer_t want;
    if (rst_ni && result_valid_o) begin
      done_cnt <= done_cnt + 1;
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected result status=%0d slot=%0d", $time, status_o, slot_o);
        error_cnt++;
      end else begin
        want = answer_q.pop_front();
        if (status_o !== want.status) begin
          $display("%0t: status mismatch expected=%0d actual=%0d", $time, want.status,
                   status_o);
          error_cnt++;
        end
        if (slot_o !== want.slot) begin
          $display("%0t: slot mismatch expected=%0d actual=%0d", $time, want.slot, slot_o);
          error_cnt++;
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d answers outstanding", $time, answer_q.size());
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int random_cnt;
    int full_mark;
    int seg_len;
    int mode;
    int pct_alloc;
    shadow_used = '0;
    shadow_ptr = 0;

    // Directed part: field extremes, next-fit order, range checks, double free.
    add_request(OP_FREE, 16'd0, 1'b0);
    add_request(OP_ALLOC, 16'hFFFF, 1'b0);
    add_request(OP_ALLOC, 16'h0000, 1'b0);
    add_request(OP_FREE, INDEX_W'(NSLOTS - 1), 1'b0);
    add_request(OP_FREE, INDEX_W'(NSLOTS), 1'b0);
    add_request(OP_FREE, 16'hFFFF, 1'b0);
    add_request(OP_FREE, 16'h8000, 1'b0);
    add_request(OP_FREE, 16'h7FFF, 1'b0);
    add_request(OP_FREE, 16'd1, 1'b0);
    add_request(OP_ALLOC, 16'h5555, 1'b0);
    add_request(OP_FREE, 16'd1, 1'b0);
    add_request(OP_ALLOC, 16'hAAAA, 1'b1);
    add_request(OP_FREE, 16'd0, 1'b0);
    add_request(OP_FREE, 16'd0, 1'b0);
    add_request(OP_ALLOC, 16'h0000, 1'b0);
    add_request(OP_ALLOC, 16'h0000, 1'b0);

    // Fill the pool with a few frees mixed in until it answers full a few times.
    random_cnt = 0;
    full_mark = full_cnt;
    add_request(OP_ALLOC, INDEX_W'($urandom_range(0, 65535)), 1'b1);
    random_cnt++;
    while (full_cnt - full_mark < 4 && random_cnt < 400) begin
      add_random_request(92, 1'b0);
      random_cnt++;
    end

    // Then segments that drain, refill or churn the pool.
    while (random_cnt < RANDOM_REQS) begin
      mode = $urandom_range(0, 2);
      seg_len = $urandom_range(40, 120);
      pct_alloc = (mode == 0) ? 90 : (mode == 1) ? 20 : 50;
      for (int k = 0; k < seg_len && random_cnt < RANDOM_REQS; k++) begin
        add_random_request(pct_alloc, k == 0 && $urandom_range(0, 1) == 1);
        random_cnt++;
      end
    end

    // Reset, then let everything drain.
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (request_q.size() != 0 || start || issued_cnt != done_cnt) @(negedge clk_i);
    repeat (NSLOTS + 8) @(negedge clk_i);
    if (answer_q.size() != 0) begin
      $display("%0t: %0d expected answers never arrived", $time, answer_q.size());
      error_cnt++;
    end

    $display("Ran %0d requests: %0d slots granted, %0d pool-full answers,", issued_cnt,
             grant_cnt, full_cnt);
    $display("%0d releases and %0d out-of-range releases.", release_cnt, range_cnt);
    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+sv
sv/nfsa_pkg.sv
sv/nfsa_map_ram.sv
sv/nfsa_ctrl.sv
sv/next_fit_slot_id_allocator_unit.sv
sv/nfsa_checker.sv
dv/next_fit_slot_id_allocator_unit_tb.sv
